FILE: hw/rtl/rem_pkg.sv
// shared types and constants for the regression error metrics block
package rem_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned ErrBits     = 16;
  localparam int unsigned CntW        = CountBits + 1;
  localparam int unsigned SqBits      = 2 * ErrBits;
  localparam int unsigned SqSumBits   = SqBits + CountBits;
  localparam int unsigned AbsSumBits  = ErrBits + CountBits;
  localparam int unsigned MsBits      = 32;
  localparam int unsigned RootBits    = MsBits / 2;
  localparam int unsigned DivSteps    = SqSumBits;
  localparam int unsigned RootSteps   = RootBits;
  localparam int unsigned StepBits    = $clog2(DivSteps);

  typedef struct packed {
    logic signed [SampleBits-1:0] actual_value;
    logic signed [SampleBits-1:0] predicted_value;
    logic                         start_new;
    logic                         report;
  } rem_in_t;

  typedef struct packed {
    logic [CntW-1:0]     sample_total;
    logic [ErrBits-1:0]  largest_error;
    logic [ErrBits-1:0]  smallest_error;
    logic [MsBits-1:0]   mean_square;
    logic [RootBits-1:0] root_mean_square;
    logic [ErrBits-1:0]  mean_absolute;
    logic                saturated;
  } rem_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_DIV_PREP,
    ST_DIVIDE,
    ST_ROOT_PREP,
    ST_ROOT,
    ST_FINISH
  } rem_state_e;

  typedef struct packed {
    logic load_sample;
    logic square;
    logic update;
    logic div_init;
    logic div_step;
    logic root_init;
    logic root_step;
    logic load_out;
  } rem_cmd_t;

  typedef struct packed {
    logic report;
  } rem_sts_t;

endpackage

FILE: hw/rtl/rem_ctrl.sv
// sequencer for sample update, divide and square root
module rem_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  rem_pkg::rem_sts_t sts_i,
  output rem_pkg::rem_cmd_t cmd_o
);
  import rem_pkg::*;

  rem_state_e          state_q, state_d;
  logic [StepBits-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                div_last, root_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign div_last  = (cnt_q == StepBits'(DivSteps - 1));
  assign root_last = (cnt_q == StepBits'(RootSteps - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE:    state_d = ST_UPDATE;
      ST_UPDATE:    state_d = sts_i.report ? ST_DIV_PREP : ST_IDLE;
      ST_DIV_PREP:  state_d = ST_DIVIDE;
      ST_DIVIDE:    if (div_last) state_d = ST_ROOT_PREP;
      ST_ROOT_PREP: state_d = ST_ROOT;
      ST_ROOT:      if (root_last) state_d = ST_FINISH;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs and step counter
  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE:      cmd_o.load_sample = in_valid_i;
      ST_SQUARE:    cmd_o.square = 1'b1;
      ST_UPDATE:    cmd_o.update = 1'b1;
      ST_DIV_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = div_last ? '0 : cnt_q + 1'b1;
      end
      ST_ROOT_PREP: cmd_o.root_init = 1'b1;
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = root_last ? '0 : cnt_q + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/rem_datapath.sv
// accumulators, long dividers for both sums, integer root and result register
module rem_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rem_pkg::rem_in_t  in_data_i,
  input  rem_pkg::rem_cmd_t cmd_i,
  output rem_pkg::rem_sts_t sts_o,
  output rem_pkg::rem_out_t out_data_o
);
  import rem_pkg::*;

  // sample capture
  logic [ErrBits-1:0]     err_q;
  logic                   start_q, report_q;
  logic [SqBits-1:0]      sq_q;
  // accumulators
  logic [CntW-1:0]        count_q, count_d;
  logic [SqSumBits-1:0]   sq_sum_q, sq_sum_d;
  logic [AbsSumBits-1:0]  abs_sum_q, abs_sum_d;
  logic [ErrBits-1:0]     max_q, max_d, min_q, min_d;
  logic                   ovf_q, ovf_d;
  // divider
  logic [SqSumBits-1:0]   dq_sq_q, dq_ab_q;
  logic [CntW-1:0]        rem_sq_q, rem_ab_q;
  // root
  logic [MsBits-1:0]      rx_q;
  logic [RootBits-1:0]    root_q;
  logic [RootBits:0]      rr_q;
  rem_out_t               out_q;

  logic signed [SampleBits:0] diff;
  logic [SampleBits:0]        mag;
  logic [CntW-1:0]            count_base;
  logic [SqSumBits-1:0]       sq_base;
  logic [AbsSumBits-1:0]      abs_base;
  logic                       ovf_base;
  logic [CntW:0]              sh_sq, sh_ab, dvs;
  logic                       ge_sq, ge_ab;
  logic [RootBits+2:0]        sh_rt, trial;
  logic                       ge_rt;
  logic                       cnt_zero;
  logic [MsBits-1:0]          ms;

  // absolute error of the incoming pair
  assign diff = $signed({in_data_i.actual_value[SampleBits-1], in_data_i.actual_value})
              - $signed({in_data_i.predicted_value[SampleBits-1], in_data_i.predicted_value});
  assign mag  = diff[SampleBits] ? (SampleBits+1)'(-diff) : diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      err_q    <= mag[ErrBits-1:0];
      start_q  <= in_data_i.start_new;
      report_q <= in_data_i.report;
    end
    if (cmd_i.square) begin
      sq_q <= SqBits'(err_q) * SqBits'(err_q);
    end
  end

  // accumulator update
  always_comb begin
    count_base = start_q ? '0 : count_q;
    sq_base    = start_q ? '0 : sq_sum_q;
    abs_base   = start_q ? '0 : abs_sum_q;
    ovf_base   = start_q ? 1'b0 : ovf_q;
    count_d    = count_base;
    sq_sum_d   = sq_base;
    abs_sum_d  = abs_base;
    max_d      = start_q ? '0 : max_q;
    min_d      = start_q ? '0 : min_q;
    ovf_d      = ovf_base;
    if (count_base[CountBits]) begin
      ovf_d = 1'b1;
    end else begin
      if (count_base == '0) begin
        max_d = err_q;
        min_d = err_q;
      end else begin
        if (err_q > max_q) max_d = err_q;
        if (err_q < min_q) min_d = err_q;
      end
      sq_sum_d  = sq_base + SqSumBits'(sq_q);
      abs_sum_d = abs_base + AbsSumBits'(err_q);
      count_d   = count_base + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sq_sum_q  <= '0;
      abs_sum_q <= '0;
      max_q     <= '0;
      min_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.update) begin
      count_q   <= count_d;
      sq_sum_q  <= sq_sum_d;
      abs_sum_q <= abs_sum_d;
      max_q     <= max_d;
      min_q     <= min_d;
      ovf_q     <= ovf_d;
    end
  end

  // restoring divide, one quotient bit per cycle for both sums
  assign dvs   = {1'b0, count_q};
  assign sh_sq = {rem_sq_q, dq_sq_q[SqSumBits-1]};
  assign sh_ab = {rem_ab_q, dq_ab_q[SqSumBits-1]};
  assign ge_sq = (sh_sq >= dvs);
  assign ge_ab = (sh_ab >= dvs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dq_sq_q  <= sq_sum_q;
      dq_ab_q  <= SqSumBits'(abs_sum_q);
      rem_sq_q <= '0;
      rem_ab_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_sq_q  <= {dq_sq_q[SqSumBits-2:0], ge_sq};
      dq_ab_q  <= {dq_ab_q[SqSumBits-2:0], ge_ab};
      rem_sq_q <= ge_sq ? CntW'(sh_sq - dvs) : sh_sq[CntW-1:0];
      rem_ab_q <= ge_ab ? CntW'(sh_ab - dvs) : sh_ab[CntW-1:0];
    end
  end

  assign cnt_zero = (count_q == '0);
  assign ms       = cnt_zero ? '0 : dq_sq_q[MsBits-1:0];

  // digit by digit square root, two radicand bits per cycle
  assign sh_rt = {rr_q, rx_q[MsBits-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge_rt = (sh_rt >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rx_q   <= ms;
      root_q <= '0;
      rr_q   <= '0;
    end else if (cmd_i.root_step) begin
      rx_q   <= {rx_q[MsBits-3:0], 2'b00};
      root_q <= {root_q[RootBits-2:0], ge_rt};
      rr_q   <= ge_rt ? (RootBits+1)'(sh_rt - trial) : sh_rt[RootBits:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.sample_total     <= count_q;
      out_q.largest_error    <= max_q;
      out_q.smallest_error   <= min_q;
      out_q.mean_square      <= ms;
      out_q.root_mean_square <= root_q;
      out_q.mean_absolute    <= cnt_zero ? '0 : dq_ab_q[ErrBits-1:0];
      out_q.saturated        <= ovf_q;
    end
  end

  assign sts_o.report = report_q;
  assign out_data_o   = out_q;

endmodule

FILE: hw/rtl/regression_error_metrics_top.sv
// top level of the running mse / mae / rmse accumulator
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in      | to block  | in_valid_i/stall_o | rem_in_t  (sample pair, flags)
//  out     | from block| out_valid_o/stall_i| rem_out_t (metrics report)
//
// a sample without report is captured, squared and accumulated
// a report adds a preparation step and the long divider (one quotient bit of the
// 48-bit squared sum per cycle), a preparation step and the root, and then the
// result register is loaded
// reset clears the accumulators and the sequencer, no result pending
// the result register holds a report while out is stalled; new samples are
// taken meanwhile, and only the next report waits for it to drain
module regression_error_metrics_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rem_pkg::rem_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rem_pkg::rem_out_t out_data_o
);
  import rem_pkg::*;

  // command and status between sequencer and datapath
  rem_cmd_t cmd;
  rem_sts_t sts;

  // state machine: stalls input outside idle, owns the out transfer valid
  rem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // accumulators, divider, root and result register
  rem_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: test/regression_error_metrics_top_test.sv
// testbench for the running mse / mae / rmse accumulator, self-checking against its own predictor
`timescale 1ns / 1ps

module regression_error_metrics_top_test;
  import rem_pkg::*;

  // run limits; CycleLimit, DrainCycles and HoldCycles in clock cycles
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned HoldAfter   = 40;
  localparam int unsigned RandomItems = 1400;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  rem_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rem_out_t out_data_o;

  regression_error_metrics_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // samples still to be offered, and reports still owed by the block
  rem_in_t  pending_samples[$];
  rem_out_t owed_reports[$];

  int unsigned total_items    = 0;
  int unsigned accepted_count = 0;
  int unsigned reports_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // set when the offered sample has gone through, cleared by the driver
  bit item_taken = 1'b0;

  // sender burst / gap shaping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // receiver stall pattern, plus the one long hold-off
  int unsigned stretch_left = 0;
  int unsigned stall_mode   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  // predicted accumulator state, starting at zero as after reset, cleared by start_new
  logic [CntW-1:0]       tally_count = '0;
  logic [SqSumBits-1:0]  tally_sq    = '0;
  logic [AbsSumBits-1:0] tally_abs   = '0;
  logic [ErrBits-1:0]    err_peak    = '0;
  logic [ErrBits-1:0]    err_floor   = '0;
  logic                  dropped     = 1'b0;

  rem_out_t got_report;
  rem_out_t want_report;

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (report %0d)",
             what, got, want, reports_seen);
    mismatches++;
  endtask

  // floor square root, settled one result bit at a time from the top
  function automatic logic [RootBits-1:0] floor_root(input logic [MsBits-1:0] x);
    logic [RootBits-1:0] r;
    logic [RootBits-1:0] trial;
    r = '0;
    for (int b = RootBits - 1; b >= 0; b--) begin
      trial = r | (RootBits'(1) << b);
      if (MsBits'(trial) * MsBits'(trial) <= x) r = trial;
    end
    return r;
  endfunction

  // fold one accepted sample into the predicted state; queue a report if asked
  task automatic absorb_sample(input rem_in_t s);
    longint          a_val;
    longint          p_val;
    longint          diff;
    longint unsigned err_abs;
    longint unsigned ms;
    longint unsigned mabs;
    rem_out_t        rep;
    a_val   = s.actual_value;
    p_val   = s.predicted_value;
    diff    = a_val - p_val;
    err_abs = (diff < 0) ? -diff : diff;

    if (s.start_new) begin
      tally_count = '0;
      tally_sq    = '0;
      tally_abs   = '0;
      err_peak    = '0;
      err_floor   = '0;
      dropped     = 1'b0;
    end

    // full count: the sample is dropped and the saturation flag sticks
    if (tally_count >= (CntW'(1) << CountBits)) begin
      dropped = 1'b1;
    end else begin
      // first sample loads both extremes, so the minimum never sticks at zero
      if (tally_count == '0) begin
        err_floor = ErrBits'(err_abs);
        err_peak  = ErrBits'(err_abs);
      end else begin
        if (ErrBits'(err_abs) < err_floor) err_floor = ErrBits'(err_abs);
        if (ErrBits'(err_abs) > err_peak)  err_peak  = ErrBits'(err_abs);
      end
      tally_sq    = tally_sq + SqSumBits'(err_abs * err_abs);
      tally_abs   = tally_abs + AbsSumBits'(err_abs);
      tally_count = tally_count + 1'b1;
    end

    if (s.report) begin
      // empty divide gives zero quotients
      if (tally_count != '0) begin
        ms   = longint'(tally_sq) / longint'(tally_count);
        mabs = longint'(tally_abs) / longint'(tally_count);
      end else begin
        ms   = 0;
        mabs = 0;
      end
      rep.sample_total     = tally_count;
      rep.largest_error    = err_peak;
      rep.smallest_error   = err_floor;
      rep.mean_square      = MsBits'(ms);
      rep.root_mean_square = floor_root(MsBits'(ms));
      rep.mean_absolute    = ErrBits'(mabs);
      rep.saturated        = dropped;
      owed_reports.push_back(rep);
    end
  endtask

  // sample values lean on the extremes and on small values around zero
  function automatic logic [SampleBits-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rem_in_t pair_item(input logic [SampleBits-1:0] a,
                                        input logic [SampleBits-1:0] p,
                                        input bit start, input bit rep);
    rem_in_t s;
    s.actual_value    = a;
    s.predicted_value = p;
    s.start_new       = start;
    s.report          = rep;
    return s;
  endfunction

  // random pair; a quarter of predictions land close to the actual value
  function automatic rem_in_t random_pair(input bit start, input bit rep);
    logic [SampleBits-1:0] a;
    logic [SampleBits-1:0] p;
    a = pick_value();
    if ($urandom_range(0, 3) == 0) p = a + 16'($urandom_range(0, 16)) - 16'd8;
    else p = pick_value();
    return pair_item(a, p, start, rep);
  endfunction

  // checking and prediction share one clocked block, output side first, so a
  // report is always matched against expectations from earlier transfers
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** regression_error_metrics_top: FAILED **");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) begin
        reports_seen++;
        got_report = out_data_o;
        if (owed_reports.size() == 0) begin
          note_mismatch("report with none expected", got_report.sample_total, 0);
        end else begin
          want_report = owed_reports.pop_front();
          if (got_report.sample_total != want_report.sample_total)
            note_mismatch("sample_total", got_report.sample_total,
                          want_report.sample_total);
          if (got_report.largest_error != want_report.largest_error)
            note_mismatch("largest_error", got_report.largest_error,
                          want_report.largest_error);
          if (got_report.smallest_error != want_report.smallest_error)
            note_mismatch("smallest_error", got_report.smallest_error,
                          want_report.smallest_error);
          if (got_report.mean_square != want_report.mean_square)
            note_mismatch("mean_square", got_report.mean_square,
                          want_report.mean_square);
          if (got_report.root_mean_square != want_report.root_mean_square)
            note_mismatch("root_mean_square", got_report.root_mean_square,
                          want_report.root_mean_square);
          if (got_report.mean_absolute != want_report.mean_absolute)
            note_mismatch("mean_absolute", got_report.mean_absolute,
                          want_report.mean_absolute);
          if (got_report.saturated != want_report.saturated)
            note_mismatch("saturated", got_report.saturated, want_report.saturated);
        end
      end
      if (rst_ni && in_valid_i && !in_stall_o) begin
        absorb_sample(in_data_i);
        accepted_count++;
        item_taken = 1'b1;
      end
    end
  end

  // sender: bursts of random length with random gaps; a stalled transfer
  // keeps its payload and valid until it goes through
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !item_taken)) begin
      item_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_data_i  <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stretches of no stall, light stall or heavy stall, and one
  // long hold-off once reports are flowing so the result register backs up
  // and the block has to stall its input
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && reports_seen >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(10, 60);
        stall_mode   = $urandom_range(0, 2);
      end
      stretch_left--;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    int unsigned made;
    int unsigned run_len;

    // directed: first sample straight from reset, largest error both ways,
    // zero error, alternating bit patterns, start_new with and without report
    pending_samples.push_back(pair_item(16'd1234, -16'sd1000, 1'b0, 1'b1));
    pending_samples.push_back(pair_item(16'h7FFF, 16'h8000, 1'b0, 1'b1));
    pending_samples.push_back(pair_item(16'h8000, 16'h7FFF, 1'b1, 1'b1));
    pending_samples.push_back(pair_item(16'h0000, 16'h0000, 1'b1, 1'b0));
    pending_samples.push_back(pair_item(16'h8000, 16'h8000, 1'b0, 1'b1));
    pending_samples.push_back(pair_item(16'h5555, 16'hAAAA, 1'b0, 1'b0));
    pending_samples.push_back(pair_item(16'hAAAA, 16'h5555, 1'b0, 1'b1));
    pending_samples.push_back(pair_item(16'hFFFF, 16'h0001, 1'b0, 1'b1));
    pending_samples.push_back(pair_item(16'h0001, 16'hFFFF, 1'b1, 1'b1));
    pending_samples.push_back(pair_item(16'h7FFF, 16'h0000, 1'b1, 1'b0));
    pending_samples.push_back(pair_item(16'h0000, 16'h7FFF, 1'b0, 1'b1));
    pending_samples.push_back(pair_item(16'h7FFF, 16'h7FFF, 1'b1, 1'b1));

    // random: mostly runs opened by start_new and closed by a report, with
    // the odd report inside; the rest is noise with free flags
    made = 0;
    while (made < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_samples.push_back(random_pair(1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1))));
        made++;
      end else begin
        run_len = $urandom_range(1, 24);
        for (int j = 0; j < run_len; j++)
          pending_samples.push_back(random_pair(j == 0,
              (j == run_len - 1) || ($urandom_range(0, 7) == 0)));
        made += run_len;
      end
    end
    total_items = pending_samples.size();

    // reset asserted at the start, released away from the rising edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all samples in, all reports out, then a quiet spell to catch strays
    while (accepted_count != total_items) @(posedge clk_i);
    while (owed_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** regression_error_metrics_top: PASSED **");
    end else begin
      $display("** regression_error_metrics_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: regression_error_metrics_top.f
hw/rtl/rem_pkg.sv
hw/rtl/rem_ctrl.sv
hw/rtl/rem_datapath.sv
hw/rtl/regression_error_metrics_top.sv
test/regression_error_metrics_top_test.sv
